// ===== rtl/fpdq_pkg.sv =====
// Shared constants and types for the dual-order (arrival / priority) queue.
// No dependencies.
package fpdq_pkg;

  localparam int CAPACITY = 16;
  localparam int ID_BITS  = 16;
  localparam int AGE_BITS = 8;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam int FUNC_W  = 3;
  localparam int ID_W    = 16;
  localparam int AGE_W   = 8;
  localparam int COUNT_W = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT   = 3'd0,
    FN_REM_PRIO = 3'd1,
    FN_REM_OLD  = 3'd2,
    FN_ABANDON  = 3'd3,
    FN_QUERY    = 3'd4
  } func_e;

  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [AGE_BITS-1:0] age;
  } entry_t;

endpackage

// ===== rtl/fpdq_ram.sv =====
// Simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module fpdq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 24,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/fifo_and_priority_dual_queue.sv =====
// Dual-order queue: entries kept compacted in arrival order in one RAM; priority is
// found by a scan (highest age, earliest arrival on ties). A removal compacts the
// entries above the removed slot by a read/write sweep. Depends on fpdq_pkg, fpdq_ram.
// One transaction at a time; start is taken again from the cycle done_o is high.
// Reset empties the queue; RAM contents are not cleared, only the count.
module fifo_and_priority_dual_queue
  import fpdq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [FUNC_W-1:0]  func_i,
  input  logic [ID_W-1:0]    id_i,
  input  logic [AGE_W-1:0]   age_i,
  output logic               done_o,
  output logic               ok_o,
  output logic [ID_W-1:0]    out_id_o,
  output logic [AGE_W-1:0]   out_age_o,
  output logic [COUNT_W-1:0] count_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT
  } state_e;

  state_e              state_q;
  logic [FUNC_W-1:0]   func_q;
  logic [ID_BITS-1:0]  id_q;
  logic [AGE_BITS-1:0] age_q;
  logic [CNT_W-1:0]    count_q;
  logic [CNT_W-1:0]    rd_idx_q;
  logic                pend_q;
  logic [IDX_W-1:0]    pend_idx_q;
  logic                found_q;
  logic [IDX_W-1:0]    fpos_q;
  logic [AGE_BITS-1:0] fage_q;
  logic [IDX_W-1:0]    best_pos_q;
  logic [ID_BITS-1:0]  best_id_q;
  logic [AGE_BITS-1:0] best_age_q;
  logic [ID_BITS-1:0]  first_id_q;
  logic [AGE_BITS-1:0] first_age_q;
  logic                ok_q;
  logic [ID_BITS-1:0]  res_id_q;
  logic [AGE_BITS-1:0] res_age_q;
  logic                done_q;

  logic                rd_issue;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  entry_t              ram_wdata;
  entry_t              ram_rdata;
  logic                accept;

  logic                dec_ok;
  logic                dec_rm;
  logic                dec_ins;
  logic [IDX_W-1:0]    dec_pos;
  logic [ID_BITS-1:0]  dec_id;
  logic [AGE_BITS-1:0] dec_age;

  assign accept   = start && (state_q == ST_IDLE);
  assign busy     = (state_q != ST_IDLE);
  assign rd_issue = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && (rd_idx_q < count_q);

  // Insert writes at the tail during DECIDE; the sweep writes slot k-1 with slot k.
  assign ram_we    = (state_q == ST_DECIDE && dec_ins) || (state_q == ST_SHIFT && pend_q);
  assign ram_waddr = (state_q == ST_DECIDE) ? count_q[IDX_W-1:0] : pend_idx_q - IDX_W'(1);
  assign ram_wdata = (state_q == ST_DECIDE) ? entry_t'({id_q, age_q}) : ram_rdata;

  fpdq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH ($bits(entry_t)),
    .AW    (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_issue),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    dec_ok  = 1'b0;
    dec_rm  = 1'b0;
    dec_ins = 1'b0;
    dec_pos = '0;
    dec_id  = '0;
    dec_age = '0;
    unique case (func_q)
      FN_INSERT: begin
        dec_ins = (id_q != '0) && (age_q != '0) && (count_q < CNT_W'(CAPACITY)) && !found_q;
        dec_ok  = dec_ins;
      end
      FN_REM_PRIO: begin
        dec_ok  = (count_q != '0);
        dec_rm  = dec_ok;
        dec_pos = best_pos_q;
        dec_id  = dec_ok ? best_id_q : '0;
        dec_age = dec_ok ? best_age_q : '0;
      end
      FN_REM_OLD: begin
        dec_ok  = (count_q != '0);
        dec_rm  = dec_ok;
        dec_id  = dec_ok ? first_id_q : '0;
        dec_age = dec_ok ? first_age_q : '0;
      end
      FN_ABANDON: begin
        dec_ok  = found_q;
        dec_rm  = found_q;
        dec_pos = fpos_q;
      end
      FN_QUERY: begin
        dec_ok  = found_q;
        dec_age = found_q ? fage_q : '0;
      end
      default: begin
        dec_ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      func_q      <= '0;
      id_q        <= '0;
      age_q       <= '0;
      count_q     <= '0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      found_q     <= 1'b0;
      fpos_q      <= '0;
      fage_q      <= '0;
      best_pos_q  <= '0;
      best_id_q   <= '0;
      best_age_q  <= '0;
      first_id_q  <= '0;
      first_age_q <= '0;
      ok_q        <= 1'b0;
      res_id_q    <= '0;
      res_age_q   <= '0;
      done_q      <= 1'b0;
    end else begin
      done_q <= 1'b0;
      pend_q <= rd_issue;
      if (rd_issue) begin
        rd_idx_q   <= rd_idx_q + CNT_W'(1);
        pend_idx_q <= rd_idx_q[IDX_W-1:0];
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            func_q   <= func_i;
            id_q     <= ID_BITS'(id_i);
            age_q    <= AGE_BITS'(age_i);
            rd_idx_q <= '0;
            found_q  <= 1'b0;
            state_q  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (pend_q) begin
            if (pend_idx_q == '0) begin
              first_id_q  <= ram_rdata.id;
              first_age_q <= ram_rdata.age;
            end
            if (pend_idx_q == '0 || ram_rdata.age > best_age_q) begin
              best_pos_q <= pend_idx_q;
              best_id_q  <= ram_rdata.id;
              best_age_q <= ram_rdata.age;
            end
            if (!found_q && ram_rdata.id == id_q) begin
              found_q <= 1'b1;
              fpos_q  <= pend_idx_q;
              fage_q  <= ram_rdata.age;
            end
          end
          if (!rd_issue && !pend_q) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          ok_q      <= dec_ok;
          res_id_q  <= dec_id;
          res_age_q <= dec_age;
          if (dec_rm) begin
            rd_idx_q <= CNT_W'(dec_pos) + CNT_W'(1);
            state_q  <= ST_SHIFT;
          end else begin
            if (dec_ins) begin
              count_q <= count_q + CNT_W'(1);
            end
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        ST_SHIFT: begin
          if (!rd_issue && !pend_q) begin
            count_q <= count_q - CNT_W'(1);
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o    = done_q;
  assign ok_o      = ok_q;
  assign out_id_o  = ID_W'(res_id_q);
  assign out_age_o = AGE_W'(res_age_q);
  assign count_o   = COUNT_W'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe longer than one cycle");

  a_no_rw_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && rd_issue) |-> (ram_waddr != rd_idx_q[IDX_W-1:0]))
    else $error("RAM read and write hit the same entry");

  a_count_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> done_q)
    else $error("count changed without a completed transaction");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after accepted transaction");

endmodule

// ===== tb/tb_fifo_and_priority_dual_queue.sv =====
// Testbench for fifo_and_priority_dual_queue: a table of directed operations, then biased random
// traffic; checked against table results or a behavioral model of the arrival/priority queue.
// Depends on fpdq_pkg and the queue RTL.
module tb_fifo_and_priority_dual_queue
  import fpdq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_W-1:0] FN_RSVD5 = 3'd5;
  localparam logic [FUNC_W-1:0] FN_RSVD6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_RSVD7 = 3'd7;
  localparam int N_RANDOM    = 1650;
  localparam int N_NO_IDLE   = 200;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic               ok;
    logic [ID_W-1:0]    out_id;
    logic [AGE_W-1:0]   out_age;
    logic [COUNT_W-1:0] count;
  } qres_t;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   id;
    logic [AGE_W-1:0]  age;
    bit                typed;
    qres_t             res;
  } op_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [FUNC_W-1:0]  func_i;
  logic [ID_W-1:0]    id_i;
  logic [AGE_W-1:0]   age_i;
  logic               done_o;
  logic               ok_o;
  logic [ID_W-1:0]    out_id_o;
  logic [AGE_W-1:0]   out_age_o;
  logic [COUNT_W-1:0] count_o;

  logic [ID_W-1:0]  arr_id[$];
  logic [AGE_W-1:0] arr_age[$];
  qres_t            pending_results[$];
  op_row_t          op_table[$];
  qres_t            want;
  int               n_fail;
  int               n_cycles;

  fifo_and_priority_dual_queue dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .func_i    (func_i),
    .id_i      (id_i),
    .age_i     (age_i),
    .done_o    (done_o),
    .ok_o      (ok_o),
    .out_id_o  (out_id_o),
    .out_age_o (out_age_o),
    .count_o   (count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int find_slot(logic [ID_W-1:0] id);
    for (int i = 0; i < arr_id.size(); i++) begin
      if (arr_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic qres_t predict_queue_op(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                                             logic [AGE_W-1:0] age);
    qres_t r;
    int    pos;
    r = '0;
    case (f)
      FN_INSERT: begin
        if (id != 0 && age != 0 && arr_id.size() < CAPACITY && find_slot(id) < 0) begin
          arr_id.push_back(id);
          arr_age.push_back(age);
          r.ok = 1'b1;
        end
      end
      FN_REM_PRIO: begin
        if (arr_id.size() > 0) begin
          pos = 0;
          for (int i = 1; i < arr_id.size(); i++) begin
            if (arr_age[i] > arr_age[pos]) pos = i;
          end
          r.ok      = 1'b1;
          r.out_id  = arr_id[pos];
          r.out_age = arr_age[pos];
          arr_id.delete(pos);
          arr_age.delete(pos);
        end
      end
      FN_REM_OLD: begin
        if (arr_id.size() > 0) begin
          r.ok      = 1'b1;
          r.out_id  = arr_id.pop_front();
          r.out_age = arr_age.pop_front();
        end
      end
      FN_ABANDON: begin
        pos = find_slot(id);
        if (pos >= 0) begin
          r.ok = 1'b1;
          arr_id.delete(pos);
          arr_age.delete(pos);
        end
      end
      FN_QUERY: begin
        pos = find_slot(id);
        if (pos >= 0) begin
          r.ok      = 1'b1;
          r.out_age = arr_age[pos];
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(arr_id.size());
    return r;
  endfunction

  task automatic add_row(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id, logic [AGE_W-1:0] age,
                         bit typed, qres_t res);
    op_row_t row;
    row.func  = f;
    row.id    = id;
    row.age   = age;
    row.typed = typed;
    row.res   = res;
    op_table.push_back(row);
  endtask

  task automatic send_op(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id, logic [AGE_W-1:0] age,
                         bit typed, qres_t res);
    qres_t r;
    @(negedge clk_i);
    start  <= 1'b1;
    func_i <= f;
    id_i   <= id;
    age_i  <= age;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    r = predict_queue_op(f, id, age);
    pending_results.push_back(typed ? res : r);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    idle_cycles(1);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45 && arr_id.size() > 0) return arr_id[$urandom_range(0, arr_id.size() - 1)];
    if (p < 85) return ID_W'($urandom_range(1, 24));
    if (p < 96) return ID_W'($urandom_range(0, 16'hFFFF));
    return '0;
  endfunction

  function automatic logic [AGE_W-1:0] pick_age();
    int p;
    p = $urandom_range(0, 99);
    if (p < 6) return '0;
    if (p < 50) return AGE_W'($urandom_range(1, 8));
    return AGE_W'($urandom_range(0, 8'hFF));
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      n_fail++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction, id %0h age %0h count %0d", $time, out_id_o,
                 out_age_o, count_o);
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        check_field("ok", 32'(want.ok), 32'(ok_o));
        check_field("out_id", 32'(want.out_id), 32'(out_id_o));
        check_field("out_age", 32'(want.out_age), 32'(out_age_o));
        check_field("count", 32'(want.count), 32'(count_o));
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("tb_fifo_and_priority_dual_queue NOT OK");
      $finish;
    end
  end

  initial begin
    logic [FUNC_W-1:0] f;
    int                bias;
    int                w_ins;
    int                r;
    bit                idle_on;
    n_fail   = 0;
    n_cycles = 0;
    start    = 1'b0;
    func_i   = '0;
    id_i     = '0;
    age_i    = '0;
    rst_ni   = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add_row(FN_REM_PRIO, 16'h0000, 8'h00, 1'b1, '{1'b0, 16'h0000, 8'h00, 5'd0});
    add_row(FN_REM_OLD,  16'h0000, 8'h00, 1'b1, '{1'b0, 16'h0000, 8'h00, 5'd0});
    add_row(FN_QUERY,    16'h0000, 8'h00, 1'b1, '{1'b0, 16'h0000, 8'h00, 5'd0});
    add_row(FN_ABANDON,  16'h0005, 8'h00, 1'b1, '{1'b0, 16'h0000, 8'h00, 5'd0});
    add_row(FN_RSVD5,    16'h0001, 8'h01, 1'b1, '{1'b0, 16'h0000, 8'h00, 5'd0});
    add_row(FN_RSVD6,    16'h0002, 8'h02, 1'b1, '{1'b0, 16'h0000, 8'h00, 5'd0});
    add_row(FN_RSVD7,    16'hFFFF, 8'hFF, 1'b1, '{1'b0, 16'h0000, 8'h00, 5'd0});
    add_row(FN_INSERT,   16'h0000, 8'h05, 1'b1, '{1'b0, 16'h0000, 8'h00, 5'd0});
    add_row(FN_INSERT,   16'h0001, 8'h00, 1'b1, '{1'b0, 16'h0000, 8'h00, 5'd0});
    add_row(FN_INSERT,   16'hFFFF, 8'hFF, 1'b1, '{1'b1, 16'h0000, 8'h00, 5'd1});
    add_row(FN_INSERT,   16'hFFFF, 8'h03, 1'b1, '{1'b0, 16'h0000, 8'h00, 5'd1});
    add_row(FN_INSERT,   16'h0001, 8'h01, 1'b1, '{1'b1, 16'h0000, 8'h00, 5'd2});
    add_row(FN_INSERT,   16'h0002, 8'hFF, 1'b1, '{1'b1, 16'h0000, 8'h00, 5'd3});
    add_row(FN_QUERY,    16'hFFFF, 8'h00, 1'b1, '{1'b1, 16'h0000, 8'hFF, 5'd3});
    add_row(FN_QUERY,    16'h0003, 8'h00, 1'b1, '{1'b0, 16'h0000, 8'h00, 5'd3});
    add_row(FN_REM_PRIO, 16'h0000, 8'h00, 1'b1, '{1'b1, 16'hFFFF, 8'hFF, 5'd2});
    add_row(FN_INSERT,   16'h0003, 8'h80, 1'b0, '0);
    add_row(FN_INSERT,   16'h0004, 8'h80, 1'b0, '0);
    add_row(FN_ABANDON,  16'h0003, 8'h00, 1'b0, '0);
    add_row(FN_REM_OLD,  16'h0000, 8'h00, 1'b0, '0);
    add_row(FN_REM_PRIO, 16'h0000, 8'h00, 1'b0, '0);
    add_row(FN_QUERY,    16'h0004, 8'h00, 1'b0, '0);
    add_row(FN_ABANDON,  16'h0004, 8'h00, 1'b0, '0);
    add_row(FN_REM_PRIO, 16'h0000, 8'h00, 1'b1, '{1'b0, 16'h0000, 8'h00, 5'd0});

    foreach (op_table[i]) begin
      if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 12));
      send_op(op_table[i].func, op_table[i].id, op_table[i].age, op_table[i].typed,
              op_table[i].res);
    end
    wait_drained();

    bias    = 0;
    idle_on = 1'b1;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 40 == 0) begin
        bias    = $urandom_range(0, 2);
        idle_on = ($urandom_range(0, 9) < 7);
      end
      if (n > 0 && n % 300 == 0 && n < N_RANDOM - N_NO_IDLE) wait_drained();
      if (n >= N_RANDOM - N_NO_IDLE) idle_on = 1'b0;
      if (idle_on && $urandom_range(0, 5) == 0) idle_cycles($urandom_range(1, 12));
      w_ins = (bias == 0) ? 65 : (bias == 1) ? 35 : 12;
      if ($urandom_range(0, 99) < w_ins) begin
        f = FN_INSERT;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 28) f = FN_REM_PRIO;
        else if (r < 50) f = FN_REM_OLD;
        else if (r < 70) f = FN_ABANDON;
        else if (r < 95) f = FN_QUERY;
        else f = FN_RSVD5 + FUNC_W'($urandom_range(0, 2));
      end
      send_op(f, pick_id(), pick_age(), 1'b0, '0);
    end
    idle_cycles(1);

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("tb_fifo_and_priority_dual_queue OK");
    end else begin
      $display("tb_fifo_and_priority_dual_queue NOT OK");
    end
    $finish;
  end

endmodule
